FILE: sv/tvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvp_pkg: shared constants and types for the trapezoid velocity profile
// Field widths, register defaults, register indexes and phase codes.
// ----------------------------------------------------------------------------
package tvp_pkg;

  localparam int POSITION_BITS_DEF = 16;

  localparam int SPEED_W   = 12;  // speed registers, mm/s
  localparam int FRAC_W    = 9;   // Q8 fractions
  localparam int MARGIN_W  = 10;  // stop margin, mm
  localparam int VEL_W     = 13;  // signed velocity outputs
  localparam int PHASE_W   = 2;

  localparam int RATIO_FRAC = 16;              // ramp ratio is Q16
  localparam int RATIO_W    = RATIO_FRAC + 1;  // ratio may reach 1.0

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [SPEED_W-1:0]  START_SPEED_RST = 12'd100;
  localparam logic [SPEED_W-1:0]  END_SPEED_RST   = 12'd100;
  localparam logic [SPEED_W-1:0]  MAX_SPEED_RST   = 12'd2000;
  localparam logic [FRAC_W-1:0]   ACCEL_FRAC_RST  = 9'd51;
  localparam logic [FRAC_W-1:0]   DECEL_FRAC_RST  = 9'd141;
  localparam logic [MARGIN_W-1:0] STOP_MARGIN_RST = 10'd10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_START_SPEED = 3'd0,
    CFG_END_SPEED   = 3'd1,
    CFG_MAX_SPEED   = 3'd2,
    CFG_ACCEL_FRAC  = 3'd3,
    CFG_DECEL_FRAC  = 3'd4,
    CFG_STOP_MARGIN = 3'd5
  } cfg_reg_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_ACCEL   = 2'd0,
    PH_CRUISE  = 2'd1,
    PH_DECEL   = 2'd2,
    PH_ARRIVED = 2'd3
  } phase_t;

endpackage

FILE: sv/tvp_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvp_isqrt: pipelined integer square root
// One root bit per stage, ROOT_W stages; floor(sqrt(rad)).
// ----------------------------------------------------------------------------
module tvp_isqrt #(
  parameter int ROOT_W = tvp_pkg::SPEED_W
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);

  logic [ROOT_W+1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [2*ROOT_W-1:0] rad_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [ROOT_W+1:0]   rem_i;
    logic [ROOT_W-1:0]   root_i;
    logic [2*ROOT_W-1:0] rad_i;
    logic [ROOT_W+3:0]   cur;
    logic [ROOT_W+3:0]   trial;
    logic [ROOT_W+3:0]   diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign rad_i  = rad_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem_i, rad_i[2*ROOT_W-1 -: 2]};
    assign trial = {2'b00, root_i, 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[ROOT_W+1:0] : cur[ROOT_W+1:0];
        root_q[k] <= {root_i[ROOT_W-2:0], ge};
        rad_q[k]  <= {rad_i[2*ROOT_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

FILE: sv/trapezoid_velocity_profile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_velocity_profile: distance based trapezoid speed planner
// Per beat: segment start/end and current position in; planned x/y velocity,
// phase and done flag out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries one position beat; output
//    channel (out_valid/out_ready) returns exactly one result beat for it,
//    in order.
//  - Configuration: cfg_we writes cfg_wdata into register cfg_addr at the
//    clock edge (0 start_speed .. 5 stop_margin); unknown indexes are dropped.
//    Write only while the pipeline is empty.
//  - Throughput: one beat per cycle unless the output stalls (see Stall).
//    Every stage is a register bank with a valid bit; no unit is shared between beats.
//  - Pipeline from accept to the output register: 3 setup stages, the
//    distance square roots (POSITION_BITS + 5 stages), 2 phase stages, the
//    17 stage ratio divider, 2 ramp stages, a 12 stage speed root, 2 stages
//    for the components and the 12 stage rounding divider, then the output
//    register.
//  - Stall: when the receiver holds out_ready low the output register keeps
//    its beat; the pipe still moves if its last stage is empty, so one
//    bubble is squeezed out and in_ready can stay high; otherwise the whole
//    pipe freezes and nothing is lost or repeated.
//  - Reset (rst, synchronous): clears all valid bits and loads the register
//    defaults; in_ready is high in the next cycle.
// ----------------------------------------------------------------------------
module trapezoid_velocity_profile #(
  parameter int POSITION_BITS = tvp_pkg::POSITION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [POSITION_BITS-1:0]       start_x,
  input  logic signed [POSITION_BITS-1:0]       start_y,
  input  logic signed [POSITION_BITS-1:0]       end_x,
  input  logic signed [POSITION_BITS-1:0]       end_y,
  input  logic signed [POSITION_BITS-1:0]       cur_x,
  input  logic signed [POSITION_BITS-1:0]       cur_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tvp_pkg::VEL_W-1:0]      vel_x,
  output logic signed [tvp_pkg::VEL_W-1:0]      vel_y,
  output logic [tvp_pkg::PHASE_W-1:0]           phase,
  output logic                                  done_res,
  input  logic                                  cfg_we,
  input  logic [tvp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [tvp_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int P    = POSITION_BITS;
  localparam int RB   = P + 5;                         // Q4 distance bits
  localparam int NW   = 2 * RB;                        // root radicand
  localparam int L12W = RB + tvp_pkg::FRAC_W;          // Q12 bounds
  localparam int AW   = (RB + 1 > tvp_pkg::MARGIN_W + 5) ? RB + 1
                                                         : tvp_pkg::MARGIN_W + 5;
  localparam int SW   = tvp_pkg::SPEED_W;
  localparam int SQW  = 2 * SW;                        // squared speed
  localparam int QW   = tvp_pkg::RATIO_W;
  localparam int QF   = tvp_pkg::RATIO_FRAC;
  localparam int CW   = SW;                            // component magnitude
  localparam int PW   = P + SW;                        // v * |d|
  localparam int N2W  = PW + 6;                        // 2*16*v*|d| + R
  localparam int RW2  = N2W - CW;                      // divider remainder
  localparam int VW   = tvp_pkg::VEL_W;
  localparam int NSTG = 3 + RB + 2 + QW + 2 + SW + 2 + CW;

  typedef struct packed {
    logic         negx;
    logic         negy;
    logic [P-1:0] dmx;
    logic [P-1:0] dmy;
  } geo_t;

  typedef struct packed {
    tvp_pkg::phase_t phase;
    logic            ramp_on;
    logic [SW-1:0]   vfix;
    logic [SQW-1:0]  b2;
    logic [SQW-1:0]  t2;
    logic            arrived;
    logic [RB-1:0]   left4;
    geo_t            geo;
  } rside_t;

  typedef struct packed {
    tvp_pkg::phase_t phase;
    logic            ramp_on;
    logic [SW-1:0]   vfix;
    logic            arrived;
    logic [RB-1:0]   left4;
    geo_t            geo;
  } vside_t;

  typedef struct packed {
    tvp_pkg::phase_t phase;
    logic            arrived;
    logic [RB-1:0]   left4;
    logic            negx;
    logic            negy;
  } cside_t;

  typedef struct packed {
    tvp_pkg::phase_t phase;
    logic            arrived;
    logic            r4z;
    logic            negx;
    logic            negy;
  } oside_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SW-1:0]                start_speed;
  logic [SW-1:0]                end_speed;
  logic [SW-1:0]                max_speed;
  logic [tvp_pkg::FRAC_W-1:0]   accel_fraction;
  logic [tvp_pkg::FRAC_W-1:0]   decel_fraction;
  logic [tvp_pkg::MARGIN_W-1:0] stop_margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_speed    <= tvp_pkg::START_SPEED_RST;
      end_speed      <= tvp_pkg::END_SPEED_RST;
      max_speed      <= tvp_pkg::MAX_SPEED_RST;
      accel_fraction <= tvp_pkg::ACCEL_FRAC_RST;
      decel_fraction <= tvp_pkg::DECEL_FRAC_RST;
      stop_margin    <= tvp_pkg::STOP_MARGIN_RST;
    end else if (cfg_we) begin
      case (tvp_pkg::cfg_reg_t'(cfg_addr))
        tvp_pkg::CFG_START_SPEED: start_speed    <= cfg_wdata[SW-1:0];
        tvp_pkg::CFG_END_SPEED:   end_speed      <= cfg_wdata[SW-1:0];
        tvp_pkg::CFG_MAX_SPEED:   max_speed      <= cfg_wdata[SW-1:0];
        tvp_pkg::CFG_ACCEL_FRAC:  accel_fraction <= cfg_wdata[tvp_pkg::FRAC_W-1:0];
        tvp_pkg::CFG_DECEL_FRAC:  decel_fraction <= cfg_wdata[tvp_pkg::FRAC_W-1:0];
        tvp_pkg::CFG_STOP_MARGIN: stop_margin    <= cfg_wdata[tvp_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: one valid bit per stage, whole pipe moves together.
  // The output register is separate so a hole in the last stage is absorbed.
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vpipe;
  logic            out_en;
  logic            en_pipe;

  assign out_en   = !out_valid || out_ready;
  assign en_pipe  = out_en || !vpipe[NSTG-1];
  assign in_ready = en_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en_pipe) begin
      vpipe <= {vpipe[NSTG-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // s1: coordinate differences and magnitudes
  // 0/1 segment, 2/3 travelled, 4/5 left to the end point
  // --------------------------------------------------------------------------
  logic signed [P:0] dif   [6];
  logic [P-1:0]      mag_c [6];
  logic [P-1:0]      m1    [6];
  geo_t              geo1;

  assign dif[0] = {start_x[P-1], start_x} - {end_x[P-1], end_x};
  assign dif[1] = {start_y[P-1], start_y} - {end_y[P-1], end_y};
  assign dif[2] = {start_x[P-1], start_x} - {cur_x[P-1], cur_x};
  assign dif[3] = {start_y[P-1], start_y} - {cur_y[P-1], cur_y};
  assign dif[4] = {end_x[P-1], end_x} - {cur_x[P-1], cur_x};
  assign dif[5] = {end_y[P-1], end_y} - {cur_y[P-1], cur_y};

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mag_c[i] = dif[i][P] ? P'(-dif[i]) : dif[i][P-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      for (int i = 0; i < 6; i++) begin
        m1[i] <= mag_c[i];
      end
      geo1 <= '{negx: dif[4][P], negy: dif[5][P], dmx: mag_c[4], dmy: mag_c[5]};
    end
  end

  // --------------------------------------------------------------------------
  // s2: squares, s3: sums scaled for a Q4 root
  // --------------------------------------------------------------------------
  logic [2*P-1:0] sq2  [6];
  geo_t           geo2;
  logic [NW-1:0]  rad3 [3];
  geo_t           geo3;

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      for (int i = 0; i < 6; i++) begin
        sq2[i] <= m1[i] * m1[i];
      end
      geo2 <= geo1;
      for (int j = 0; j < 3; j++) begin
        rad3[j] <= {1'b0, ({1'b0, sq2[2*j]} + {1'b0, sq2[2*j+1]}), 8'b0};
      end
      geo3 <= geo2;
    end
  end

  // --------------------------------------------------------------------------
  // Distance roots: length, travelled, left (all Q4 mm)
  // --------------------------------------------------------------------------
  logic [RB-1:0] dist4  [3];
  geo_t          geo_dl [RB];

  for (genvar j = 0; j < 3; j++) begin : g_dist
    tvp_isqrt #(.ROOT_W(RB)) u_root (
      .clk  (clk),
      .en   (en_pipe),
      .rad  (rad3[j]),
      .root (dist4[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      geo_dl[0] <= geo3;
      for (int i = 1; i < RB; i++) begin
        geo_dl[i] <= geo_dl[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // s4: arrival test and Q12 phase bounds
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] gap_c;
  logic signed [AW-1:0] thr_c;
  logic [L12W-1:0]      acc_c;
  logic [L12W-1:0]      dec_c;

  logic                 arrived4;
  logic [L12W-1:0]      acc4;
  logic [L12W-1:0]      dec4;
  logic [RB-1:0]        len4;
  logic [RB-1:0]        trav4;
  logic [RB-1:0]        left4;
  geo_t                 geo4;

  assign gap_c = $signed(AW'(dist4[0])) - $signed(AW'(dist4[1]));
  assign thr_c = $signed(AW'({stop_margin, 4'b0000}));
  assign acc_c = dist4[0] * accel_fraction;
  assign dec_c = dist4[0] * decel_fraction;

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      arrived4 <= (gap_c < thr_c);
      acc4     <= acc_c;
      dec4     <= dec_c;
      len4     <= dist4[0];
      trav4    <= dist4[1];
      left4    <= dist4[2];
      geo4     <= geo_dl[RB-1];
    end
  end

  // --------------------------------------------------------------------------
  // s5: phase choice, ramp operands, squared speeds
  // --------------------------------------------------------------------------
  logic [L12W-1:0]        len12;
  logic [L12W-1:0]        trav12;
  logic signed [L12W:0]   cruise_end;
  logic                   lt_acc;
  logic                   lt_cru;
  logic                   lt_len;
  tvp_pkg::phase_t        ph_c;
  logic                   ramp_c;
  logic [SW-1:0]          vfix_c;
  logic [SW-1:0]          base_c;
  logic [L12W-1:0]        num_c;
  logic [L12W-1:0]        den_c;

  logic [L12W-1:0]        num5;
  logic [L12W-1:0]        den5;
  rside_t                 side5;

  assign len12      = L12W'({len4, 8'b0});
  assign trav12     = L12W'({trav4, 8'b0});
  assign cruise_end = $signed({1'b0, len12}) - $signed({1'b0, dec4});
  assign lt_acc     = (trav12 < acc4);
  assign lt_cru     = ($signed({1'b0, trav12}) < cruise_end);
  assign lt_len     = (trav12 < len12);

  always_comb begin
    ph_c   = tvp_pkg::PH_DECEL;
    ramp_c = 1'b0;
    vfix_c = end_speed;
    base_c = end_speed;
    num_c  = '0;
    den_c  = acc4;
    if (lt_acc) begin
      ph_c   = tvp_pkg::PH_ACCEL;
      ramp_c = 1'b1;
      base_c = start_speed;
      num_c  = trav12;
    end else if (lt_cru) begin
      ph_c   = tvp_pkg::PH_CRUISE;
      vfix_c = max_speed;
    end else if (lt_len) begin
      ramp_c = 1'b1;
      num_c  = len12 - trav12;
      den_c  = dec4;
    end
  end

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      num5          <= num_c;
      den5          <= den_c;
      side5.phase   <= ph_c;
      side5.ramp_on <= ramp_c;
      side5.vfix    <= vfix_c;
      side5.b2      <= base_c * base_c;
      side5.t2      <= max_speed * max_speed;
      side5.arrived <= arrived4;
      side5.left4   <= left4;
      side5.geo     <= geo4;
    end
  end

  // --------------------------------------------------------------------------
  // Ramp ratio divider: floor(num * 2^16 / den), num <= den, one bit a stage
  // --------------------------------------------------------------------------
  logic [L12W-1:0] r1  [QW];
  logic [QW-1:0]   q1  [QW];
  logic [L12W-1:0] dn1 [QW];
  rside_t          sd1 [QW];

  for (genvar k = 0; k < QW; k++) begin : g_ratio
    logic [L12W-1:0] r_i;
    logic [L12W-1:0] d_i;
    logic [QW-1:0]   q_i;
    rside_t          s_i;
    logic [L12W:0]   t_i;
    logic [L12W:0]   sub_i;
    logic            ge_i;

    if (k == 0) begin : g_first
      assign r_i = num5;
      assign d_i = den5;
      assign q_i = '0;
      assign s_i = side5;
      assign t_i = {1'b0, num5};
    end else begin : g_next
      assign r_i = r1[k-1];
      assign d_i = dn1[k-1];
      assign q_i = q1[k-1];
      assign s_i = sd1[k-1];
      assign t_i = {r_i, 1'b0};
    end

    assign ge_i  = (t_i >= {1'b0, d_i});
    assign sub_i = t_i - {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (en_pipe) begin
        r1[k]  <= ge_i ? sub_i[L12W-1:0] : t_i[L12W-1:0];
        q1[k]  <= {q_i[QW-2:0], ge_i};
        dn1[k] <= d_i;
        sd1[k] <= s_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // s6: scaled part of the squared-speed span, s7: squared speed
  // --------------------------------------------------------------------------
  rside_t            rs;
  logic              dneg_c;
  logic [SQW-1:0]    dmag_c;
  logic [SQW+QW-1:0] pprod_c;

  logic [SQW-1:0]    part6;
  logic [SQW-1:0]    b26;
  logic              dneg6;
  vside_t            vside6;
  logic [SQW:0]      vsum_c;
  logic [SQW-1:0]    v27;
  vside_t            vside7;

  assign rs      = sd1[QW-1];
  assign dneg_c  = (rs.t2 < rs.b2);
  assign dmag_c  = dneg_c ? (rs.b2 - rs.t2) : (rs.t2 - rs.b2);
  assign pprod_c = dmag_c * q1[QW-1];
  assign vsum_c  = dneg6 ? ({1'b0, b26} - {1'b0, part6}) : ({1'b0, b26} + {1'b0, part6});

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      part6  <= pprod_c[SQW+QF-1:QF];
      b26    <= rs.b2;
      dneg6  <= dneg_c;
      vside6 <= '{phase: rs.phase, ramp_on: rs.ramp_on, vfix: rs.vfix,
                  arrived: rs.arrived, left4: rs.left4, geo: rs.geo};
      v27    <= vsum_c[SQW-1:0];
      vside7 <= vside6;
    end
  end

  // --------------------------------------------------------------------------
  // Speed root
  // --------------------------------------------------------------------------
  logic [SW-1:0] vroot;
  vside_t        vside_dl [SW];

  tvp_isqrt #(.ROOT_W(SW)) u_speed_root (
    .clk  (clk),
    .en   (en_pipe),
    .rad  (v27),
    .root (vroot)
  );

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      vside_dl[0] <= vside7;
      for (int i = 1; i < SW; i++) begin
        vside_dl[i] <= vside_dl[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // s8: v * |d|, s9: rounding dividend 2*16*v*|d| + R and divisor 2*R
  // --------------------------------------------------------------------------
  vside_t         vs;
  logic [SW-1:0]  v_c;
  logic [PW-1:0]  prodx8;
  logic [PW-1:0]  prody8;
  cside_t         cside8;
  logic [N2W-1:0] n2x9;
  logic [N2W-1:0] n2y9;
  logic [RW2-1:0] d29;
  oside_t         oside9;

  assign vs  = vside_dl[SW-1];
  assign v_c = vs.ramp_on ? vroot : vs.vfix;

  always_ff @(posedge clk) begin
    if (en_pipe) begin
      prodx8 <= v_c * vs.geo.dmx;
      prody8 <= v_c * vs.geo.dmy;
      cside8 <= '{phase: vs.phase, arrived: vs.arrived, left4: vs.left4,
                  negx: vs.geo.negx, negy: vs.geo.negy};
      n2x9   <= {1'b0, prodx8, 5'b0} + N2W'(cside8.left4);
      n2y9   <= {1'b0, prody8, 5'b0} + N2W'(cside8.left4);
      d29    <= RW2'({cside8.left4, 1'b0});
      oside9 <= '{phase: cside8.phase, arrived: cside8.arrived,
                  r4z: (cside8.left4 == '0), negx: cside8.negx, negy: cside8.negy};
    end
  end

  // --------------------------------------------------------------------------
  // Component divider, x and y lanes; quotient fits CW bits since |c| <= v
  // --------------------------------------------------------------------------
  logic [RW2-1:0] rx2 [CW];
  logic [RW2-1:0] ry2 [CW];
  logic [CW-1:0]  lx2 [CW];
  logic [CW-1:0]  ly2 [CW];
  logic [CW-1:0]  qx2 [CW];
  logic [CW-1:0]  qy2 [CW];
  logic [RW2-1:0] dd2 [CW];
  oside_t         sd2 [CW];

  for (genvar k = 0; k < CW; k++) begin : g_comp
    logic [RW2-1:0] rx_i;
    logic [RW2-1:0] ry_i;
    logic [CW-1:0]  lx_i;
    logic [CW-1:0]  ly_i;
    logic [CW-1:0]  qx_i;
    logic [CW-1:0]  qy_i;
    logic [RW2-1:0] d_i;
    oside_t         s_i;
    logic [RW2:0]   tx_i;
    logic [RW2:0]   ty_i;
    logic [RW2:0]   sx_i;
    logic [RW2:0]   sy_i;
    logic           gx_i;
    logic           gy_i;

    if (k == 0) begin : g_first
      assign rx_i = n2x9[N2W-1:CW];
      assign ry_i = n2y9[N2W-1:CW];
      assign lx_i = n2x9[CW-1:0];
      assign ly_i = n2y9[CW-1:0];
      assign qx_i = '0;
      assign qy_i = '0;
      assign d_i  = d29;
      assign s_i  = oside9;
    end else begin : g_next
      assign rx_i = rx2[k-1];
      assign ry_i = ry2[k-1];
      assign lx_i = lx2[k-1];
      assign ly_i = ly2[k-1];
      assign qx_i = qx2[k-1];
      assign qy_i = qy2[k-1];
      assign d_i  = dd2[k-1];
      assign s_i  = sd2[k-1];
    end

    assign tx_i = {rx_i, lx_i[CW-1]};
    assign ty_i = {ry_i, ly_i[CW-1]};
    assign gx_i = (tx_i >= {1'b0, d_i});
    assign gy_i = (ty_i >= {1'b0, d_i});
    assign sx_i = tx_i - {1'b0, d_i};
    assign sy_i = ty_i - {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (en_pipe) begin
        rx2[k] <= gx_i ? sx_i[RW2-1:0] : tx_i[RW2-1:0];
        ry2[k] <= gy_i ? sy_i[RW2-1:0] : ty_i[RW2-1:0];
        lx2[k] <= {lx_i[CW-2:0], 1'b0};
        ly2[k] <= {ly_i[CW-2:0], 1'b0};
        qx2[k] <= {qx_i[CW-2:0], gx_i};
        qy2[k] <= {qy_i[CW-2:0], gy_i};
        dd2[k] <= d_i;
        sd2[k] <= s_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: signs, arrival override, zero-distance override
  // --------------------------------------------------------------------------
  oside_t        os;
  logic [VW-1:0] px;
  logic [VW-1:0] py;
  logic [VW-1:0] nx;
  logic [VW-1:0] ny;
  logic          zero_vel;

  assign os       = sd2[CW-1];
  assign px       = {1'b0, qx2[CW-1]};
  assign py       = {1'b0, qy2[CW-1]};
  assign nx       = -px;
  assign ny       = -py;
  assign zero_vel = os.arrived || os.r4z;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= vpipe[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      // x is reported against the direction to the end point
      vel_x    <= zero_vel ? '0 : $signed(os.negx ? px : nx);
      vel_y    <= zero_vel ? '0 : $signed(os.negy ? ny : py);
      phase    <= os.arrived ? tvp_pkg::PH_ARRIVED : os.phase;
      done_res <= os.arrived;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> (phase == tvp_pkg::PH_ARRIVED) && (vel_x == '0) && (vel_y == '0))
    else $error("arrived beat with nonzero velocity or wrong phase");

  a_phase_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == tvp_pkg::PH_ARRIVED) |-> done_res)
    else $error("arrived phase without done");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vpipe[0])
    else $error("accepted beat not tracked in first stage");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output register is empty");

endmodule
